// ===== hdl/i2ctrp_pkg.sv =====
// ============================================================================
// I2C target register pointer - shared definitions
// Register map constants, bus event codes, bus phase type and the structs
// passed between the event logic and the top level.
// ============================================================================
package i2ctrp_pkg;

    localparam logic [7:0] CONFIG_BASE     = 8'd0;
    localparam logic [7:0] DISTANCE_BASE   = 8'd16;
    localparam logic [7:0] DEFAULT_ADDRESS = 8'd82;

    // Bus event codes
    localparam logic [2:0] OP_ADDR_WRITE = 3'd0;
    localparam logic [2:0] OP_ADDR_READ  = 3'd1;
    localparam logic [2:0] OP_DATA_RX    = 3'd2;
    localparam logic [2:0] OP_MASTER_ACK = 3'd3;
    localparam logic [2:0] OP_MASTER_NAK = 3'd4;

    // Configuration register indexes
    localparam logic CFG_AUTO_INCREMENT = 1'b0;
    localparam logic CFG_SECONDARY_ADDR = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_REG  = 2'd1,
        PH_SENDING   = 2'd2,
        PH_RECEIVING = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] pointer;
        logic [7:0] config_low;
        logic [7:0] config_high;
        logic [7:0] device_address;
    } regs_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] rx_byte;
        logic [7:0] right_distance;
        logic [7:0] left_distance;
        logic [7:0] min_distance;
        logic [7:0] max_distance;
        logic [7:0] avg_distance;
    } event_t;

    typedef struct packed {
        logic [7:0] stored_address;
        logic       store_address;
        logic       clear_conversion_done;
        logic       ack_bit;
        logic       ack_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } result_t;

    function automatic logic in_config(input logic [7:0] r);
        return ({1'b0, r} >= {1'b0, CONFIG_BASE}) &&
               ({1'b0, r} <= {1'b0, CONFIG_BASE} + 9'd2);
    endfunction

    function automatic logic in_distance(input logic [7:0] r);
        return ({1'b0, r} >= {1'b0, DISTANCE_BASE}) &&
               ({1'b0, r} <= {1'b0, DISTANCE_BASE} + 9'd4);
    endfunction

    // Pointer advance, wrapping within the config or distance group; holds without auto-increment
    function automatic logic [7:0] next_reg(input logic [7:0] r, input logic auto_inc);
        logic [8:0] v;
        logic [7:0] n;
        v = {1'b0, r} + 9'd1;
        if (!auto_inc) begin
            n = r;
        end else if (in_config(r)) begin
            n = (v > {1'b0, CONFIG_BASE} + 9'd2) ? CONFIG_BASE : v[7:0];
        end else begin
            n = ({1'b0, v[7:0]} > {1'b0, DISTANCE_BASE} + 9'd4) ? DISTANCE_BASE : v[7:0];
        end
        return n;
    endfunction

endpackage

// ===== hdl/i2ctrp_event.sv =====
// ============================================================================
// I2C target register pointer - event logic
// Decodes one bus event against the current register state and produces the
// next register state and the result of the event.
// ============================================================================
module i2ctrp_event
    import i2ctrp_pkg::*;
(
    input  event_t  ev,
    input  regs_t   cur,
    input  logic    auto_increment,
    input  logic    secondary_address_mode,
    output regs_t   nxt,
    output result_t res
);

    logic [7:0] cfg_k;
    logic [7:0] dist_k;
    logic [7:0] wr_k;
    logic [7:0] read_byte;
    logic       read_clear;

    assign cfg_k  = cur.pointer - CONFIG_BASE;
    assign dist_k = cur.pointer - DISTANCE_BASE;
    assign wr_k   = cur.pointer - CONFIG_BASE;

    // Read mux for the pointed register; config meaning wins on overlap
    always_comb
    begin
        read_byte  = 8'd0;
        read_clear = 1'b0;
        if (in_config(cur.pointer)) begin
            case (cfg_k[1:0])
                2'd0:    read_byte = cur.config_low;
                2'd1:    read_byte = cur.config_high;
                default: read_byte = cur.device_address;
            endcase
        end else if (in_distance(cur.pointer)) begin
            read_clear = 1'b1;
            case (dist_k[2:0])
                3'd0:    read_byte = ev.right_distance;
                3'd1:    read_byte = ev.left_distance;
                3'd2:    read_byte = ev.min_distance;
                3'd3:    read_byte = ev.max_distance;
                default: read_byte = ev.avg_distance;
            endcase
        end
    end

    always_comb
    begin
        nxt = cur;
        res = '0;
        case (ev.operation)
            OP_ADDR_WRITE:
            begin
                nxt.phase = PH_WAIT_REG;
            end
            OP_ADDR_READ, OP_MASTER_ACK:
            begin
                if (ev.operation == OP_ADDR_READ) begin
                    nxt.phase = PH_SENDING;
                end
                res.tx_valid              = 1'b1;
                res.tx_byte               = read_byte;
                res.clear_conversion_done = read_clear;
                nxt.pointer               = next_reg(cur.pointer, auto_increment);
            end
            OP_DATA_RX:
            begin
                res.ack_valid = 1'b1;
                if (cur.phase == PH_WAIT_REG) begin
                    if (in_config(ev.rx_byte) || in_distance(ev.rx_byte)) begin
                        nxt.pointer = ev.rx_byte;
                        nxt.phase   = PH_RECEIVING;
                    end else begin
                        // refuse a byte that names no register
                        res.ack_bit = 1'b1;
                    end
                end else begin
                    if (in_config(cur.pointer)) begin
                        case (wr_k[1:0])
                            2'd0:    nxt.config_low  = ev.rx_byte;
                            2'd1:    nxt.config_high = ev.rx_byte;
                            default:
                            begin
                                if (!secondary_address_mode) begin
                                    nxt.device_address = ev.rx_byte;
                                end
                                res.store_address  = 1'b1;
                                res.stored_address = ev.rx_byte;
                            end
                        endcase
                    end
                    if (auto_increment) begin
                        nxt.pointer = next_reg(cur.pointer, auto_increment);
                    end else begin
                        nxt.phase = PH_WAIT_REG;
                    end
                end
            end
            default:
            begin
                // master nack and unused codes: no action
            end
        endcase
    end

endmodule

// ===== hdl/i2c_target_register_pointer_core.sv =====
// ============================================================================
// I2C target register pointer core
// Byte-level register map logic for an I2C target: register pointer, config
// bytes and device address, driven by one bus event per transaction.
// ============================================================================
//
// Channel   Direction  Payload
// s_axis    in         tuser: operation; tdata: rx_byte and five distances
// m_axis    out        tdata: tx, ack, clear, store flags and bytes
// cfg       in         write-only: auto_increment, secondary_address_mode
//
// One event per cycle while the result side is not stalled: an input stage
// register feeds the event logic, which updates the register state and loads
// the result register on the same edge. A stalled result register holds and
// backpressures the input stage; both stages advance together whenever the
// result is taken.
// Reset clears the pointer, phase, config bytes and both mode bits, and
// loads the default device address.
module i2c_target_register_pointer_core
    import i2ctrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] rx_byte, [15:8] right_distance, [23:16] left_distance,
    // [31:24] min_distance, [39:32] max_distance, [47:40] avg_distance
    input  logic [47:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] ack_valid, [10] ack_bit,
    // [11] clear_conversion_done, [12] store_address, [20:13] stored_address,
    // [23:21] zero
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic    in_valid_reg;
    event_t  in_event_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    regs_t   regs_reg;
    regs_t   regs_next;
    result_t result_next;
    logic    auto_increment_reg;
    logic    secondary_mode_reg;
    logic    advance;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    i2ctrp_event u_event (
        .ev                     (in_event_reg),
        .cur                    (regs_reg),
        .auto_increment         (auto_increment_reg),
        .secondary_address_mode (secondary_mode_reg),
        .nxt                    (regs_next),
        .res                    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            auto_increment_reg <= 1'b0;
            secondary_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_AUTO_INCREMENT: auto_increment_reg <= cfg_data;
                CFG_SECONDARY_ADDR: secondary_mode_reg <= cfg_data;
                default:            auto_increment_reg <= auto_increment_reg;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_event_reg.operation      <= s_axis_tuser;
            in_event_reg.rx_byte        <= s_axis_tdata[7:0];
            in_event_reg.right_distance <= s_axis_tdata[15:8];
            in_event_reg.left_distance  <= s_axis_tdata[23:16];
            in_event_reg.min_distance   <= s_axis_tdata[31:24];
            in_event_reg.max_distance   <= s_axis_tdata[39:32];
            in_event_reg.avg_distance   <= s_axis_tdata[47:40];
        end
    end

    // Register state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            regs_reg.phase          <= PH_IDLE;
            regs_reg.pointer        <= 8'd0;
            regs_reg.config_low     <= 8'd0;
            regs_reg.config_high    <= 8'd0;
            regs_reg.device_address <= DEFAULT_ADDRESS;
            out_valid_reg           <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                regs_reg <= regs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg) begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_result_reg};

endmodule

// ===== tb/sv/i2c_register_map_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C register map checker
// Watches the event and result streams and the config write port of the
// register pointer core. Keeps its own copy of the bus phase, pointer, config
// bytes, device address and mode bits, and predicts one result per accepted
// event. Compares every result field by field with the oldest prediction and
// counts mismatches for the top level.
// ============================================================================
module i2c_register_map_checker
    import i2ctrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output int          mismatch_count,
    output int          pending_count
);

    phase_t     bus_phase;
    logic [7:0] reg_pointer;
    logic [7:0] config_low;
    logic [7:0] config_high;
    logic [7:0] device_address;
    logic       auto_inc;
    logic       secondary_mode;

    result_t    expected_results[$];
    result_t    want;
    result_t    got;

    function automatic logic is_config_reg(input logic [7:0] r);
        return ({1'b0, r} >= {1'b0, CONFIG_BASE}) && ({1'b0, r} <= {1'b0, CONFIG_BASE} + 9'd2);
    endfunction

    function automatic logic is_distance_reg(input logic [7:0] r);
        return ({1'b0, r} >= {1'b0, DISTANCE_BASE}) &&
               ({1'b0, r} <= {1'b0, DISTANCE_BASE} + 9'd4);
    endfunction

    function automatic logic [7:0] advance_pointer(input logic [7:0] r);
        logic [8:0] bumped;
        bumped = {1'b0, r} + 9'd1;
        if (!auto_inc)
            return r;
        if (is_config_reg(r))
            return (bumped > {1'b0, CONFIG_BASE} + 9'd2) ? CONFIG_BASE : bumped[7:0];
        // Outside the config group count modulo 256 and wrap past the last distance
        if ({1'b0, bumped[7:0]} > {1'b0, DISTANCE_BASE} + 9'd4)
            return DISTANCE_BASE;
        return bumped[7:0];
    endfunction

    function automatic logic [7:0] read_register(input logic [7:0] r,
                                                 input logic [39:0] distances,
                                                 output logic clear_done);
        logic [7:0] offset;
        clear_done = 1'b0;
        if (is_config_reg(r)) begin
            offset = r - CONFIG_BASE;
            if (offset == 8'd0)
                return config_low;
            if (offset == 8'd1)
                return config_high;
            return device_address;
        end
        if (is_distance_reg(r)) begin
            offset = r - DISTANCE_BASE;
            clear_done = 1'b1;
            return distances[8 * offset +: 8];
        end
        return 8'd0;
    endfunction

    function automatic result_t apply_bus_event(input logic [2:0] op, input logic [7:0] rx,
                                                input logic [39:0] distances);
        result_t    r;
        logic [7:0] offset;
        logic       clear_done;
        r = '0;
        case (op)
            OP_ADDR_WRITE: bus_phase = PH_WAIT_REG;
            OP_ADDR_READ, OP_MASTER_ACK: begin
                if (op == OP_ADDR_READ)
                    bus_phase = PH_SENDING;
                r.tx_valid = 1'b1;
                r.tx_byte = read_register(reg_pointer, distances, clear_done);
                r.clear_conversion_done = clear_done;
                reg_pointer = advance_pointer(reg_pointer);
            end
            OP_DATA_RX: begin
                r.ack_valid = 1'b1;
                if (bus_phase == PH_WAIT_REG) begin
                    if (is_config_reg(rx) || is_distance_reg(rx)) begin
                        reg_pointer = rx;
                        bus_phase = PH_RECEIVING;
                    end else begin
                        r.ack_bit = 1'b1;
                    end
                end else begin
                    // Distance and unknown registers drop the byte but still ack it
                    if (is_config_reg(reg_pointer)) begin
                        offset = reg_pointer - CONFIG_BASE;
                        if (offset == 8'd0) begin
                            config_low = rx;
                        end else if (offset == 8'd1) begin
                            config_high = rx;
                        end else begin
                            if (!secondary_mode)
                                device_address = rx;
                            r.store_address = 1'b1;
                            r.stored_address = rx;
                        end
                    end
                    if (auto_inc)
                        reg_pointer = advance_pointer(reg_pointer);
                    else
                        bus_phase = PH_WAIT_REG;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            bus_phase = PH_IDLE;
            reg_pointer = 8'd0;
            config_low = 8'd0;
            config_high = 8'd0;
            device_address = DEFAULT_ADDRESS;
            auto_inc = 1'b0;
            secondary_mode = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_AUTO_INCREMENT)
                    auto_inc = cfg_data;
                else
                    secondary_mode = cfg_data;
            end

            // Retire before predicting: an event cannot produce its result on the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[20:0]);
                if (expected_results.size() == 0) begin
                    $error("result transaction with no event pending: tdata %06h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("ack_valid", 8'(want.ack_valid), 8'(got.ack_valid));
                    check_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
                    check_field("clear_conversion_done", 8'(want.clear_conversion_done),
                                8'(got.clear_conversion_done));
                    check_field("store_address", 8'(want.store_address),
                                8'(got.store_address));
                    check_field("stored_address", want.stored_address, got.stored_address);
                    check_field("tdata_pad", 8'd0, 8'(m_axis_tdata[23:21]));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_bus_event(s_axis_tuser, s_axis_tdata[7:0],
                                                           s_axis_tdata[47:8]));
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_i2c_target_register_pointer_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C target register pointer core testbench
// Drives bus events into the core through the input stream, with a directed
// opening and then mostly well-formed write and read transfers with random
// content, across several mode settings. Both stream sides idle in bursts;
// one long result stall backs the core up. The checker instance predicts and
// compares; this module makes stimulus and gives the verdict.
// ============================================================================
module tb_i2c_target_register_pointer_core;
    import i2ctrp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_COUNT = 6;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;

    int          mismatch_count;
    int          pending_count;
    int          phase_items;
    logic        auto_inc_now;
    logic        gaps_allowed;
    logic        sender_gaps_on;
    logic        hold_request;
    logic        rx_quiet;
    logic        rx_bursty;

    logic        auto_inc_seq[PHASE_COUNT]       = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic        secondary_mode_seq[PHASE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    i2c_target_register_pointer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    i2c_register_map_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [39:0] random_distances();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Mostly one of the eight registers, now and then any byte
    function automatic logic [7:0] choose_register_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return CONFIG_BASE + 8'(pick);
        if (pick < 8)
            return DISTANCE_BASE + 8'(pick - 3);
        return 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_event(input logic [2:0] op, input logic [7:0] rx,
                              input logic [39:0] distances);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {distances, rx};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        phase_items++;
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
    endtask

    task automatic set_modes(input logic auto_inc, input logic secondary_mode);
        cfg_we <= 1'b1;
        cfg_index <= CFG_AUTO_INCREMENT;
        cfg_data <= auto_inc;
        @(negedge clk);
        cfg_index <= CFG_SECONDARY_ADDR;
        cfg_data <= secondary_mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        auto_inc_now = auto_inc;
    endtask

    task automatic run_random_traffic(input int target);
        int kind;
        int count;
        int k;
        phase_items = 0;
        while (phase_items < target) begin
            sender_gaps_on = gaps_allowed && ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // Register write transfer; without auto-increment every data byte
                // is preceded by a fresh register byte
                send_event(OP_ADDR_WRITE, 8'($urandom), random_distances());
                send_event(OP_DATA_RX, choose_register_byte(), random_distances());
                count = $urandom_range(1, 4);
                for (k = 0; k < count; k++) begin
                    if (!auto_inc_now && k > 0)
                        send_event(OP_DATA_RX, choose_register_byte(), random_distances());
                    send_event(OP_DATA_RX, 8'($urandom), random_distances());
                end
            end else if (kind < 8) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_event(OP_ADDR_WRITE, 8'($urandom), random_distances());
                    send_event(OP_DATA_RX, choose_register_byte(), random_distances());
                end
                send_event(OP_ADDR_READ, 8'($urandom), random_distances());
                count = $urandom_range(0, 6);
                for (k = 0; k < count; k++)
                    send_event(OP_MASTER_ACK, 8'($urandom), random_distances());
                send_event(OP_MASTER_NAK, 8'($urandom), random_distances());
            end else begin
                send_event(3'($urandom_range(0, 7)),
                           ($urandom_range(0, 1) == 1) ? choose_register_byte() : 8'($urandom),
                           random_distances());
            end
        end
    endtask

    // Result side: random stall bursts, one long hold on request, none at the end
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!rx_quiet && rx_bursty && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ($urandom_range(0, 49) == 0)
                rx_bursty = !rx_bursty;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("i2c_target_register_pointer_core verification failed");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ADDR_WRITE;
        cfg_we = 1'b0;
        cfg_index = CFG_AUTO_INCREMENT;
        cfg_data = 1'b0;
        auto_inc_now = 1'b0;
        gaps_allowed = 1'b1;
        sender_gaps_on = 1'b0;
        hold_request = 1'b0;
        rx_quiet = 1'b0;
        rx_bursty = 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening, no auto-increment, live address updates
        set_modes(1'b0, 1'b0);
        send_event(OP_MASTER_ACK, 8'h00, '0);
        send_event(OP_DATA_RX, 8'hFF, '1);
        send_event(OP_DATA_RX, 8'hFF, '1);
        send_event(OP_DATA_RX, DISTANCE_BASE + 8'd5, '0);
        send_event(OP_DATA_RX, CONFIG_BASE + 8'd3, '0);
        send_event(OP_DATA_RX, DISTANCE_BASE - 8'd1, '0);
        send_event(OP_DATA_RX, CONFIG_BASE + 8'd2, '0);
        send_event(OP_DATA_RX, 8'h00, '0);
        send_event(OP_ADDR_READ, 8'h00, '1);
        send_event(OP_DATA_RX, 8'h5A, '0);
        send_event(OP_DATA_RX, DISTANCE_BASE + 8'd4, '0);
        send_event(OP_DATA_RX, 8'h77, '1);
        send_event(OP_ADDR_READ, 8'h00, '1);
        send_event(OP_MASTER_ACK, 8'h00, '0);
        send_event(OP_MASTER_NAK, 8'hFF, '1);
        for (int k = 1; k <= 3; k++)
            send_event(OP_MASTER_NAK + 3'(k), 8'hFF, '1);
        send_event(OP_ADDR_WRITE, 8'hFF, '1);
        send_event(OP_DATA_RX, DISTANCE_BASE, random_distances());
        send_event(OP_ADDR_READ, 8'h00, random_distances());
        send_event(OP_ADDR_WRITE, 8'h00, '0);
        send_event(OP_DATA_RX, CONFIG_BASE + 8'd1, '0);
        send_event(OP_DATA_RX, 8'hA5, '0);
        send_event(OP_ADDR_READ, 8'h00, '0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_for_drain();
            set_modes(auto_inc_seq[p], secondary_mode_seq[p]);
            if (p == PHASE_COUNT - 1) begin
                gaps_allowed = 1'b0;
                rx_quiet = 1'b1;
            end
            if (p == 1) begin
                // Keep offering back to back while results are held off
                hold_request = 1'b1;
                gaps_allowed = 1'b0;
                run_random_traffic(20);
                gaps_allowed = 1'b1;
                run_random_traffic(195);
            end else begin
                run_random_traffic(215);
            end
        end

        wait_for_drain();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("i2c_target_register_pointer_core verification clean");
        else
            $display("i2c_target_register_pointer_core verification failed");
        $finish;
    end

endmodule
